### sv/zst_pkg.sv
// ----------------------------------------------------------------------------
// zst_pkg
// Shared types, constants and the pixel decision function for the
// Zhang-Suen thinning pass.
// ----------------------------------------------------------------------------
`default_nettype none

package zst_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int DIM_W      = 11;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = 4;

    typedef logic [PIX_W-1:0]     t_pix;
    typedef logic [DIM_W-1:0]     t_dim;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [COL_W-1:0]     t_col;
    typedef logic [ROW_W-1:0]     t_row;

    localparam t_cfg_idx CFG_FRAME_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_FRAME_HEIGHT = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_PASS_PHASE   = t_cfg_idx'(2);

    localparam t_dim WIDTH_RESET  = t_dim'(640);
    localparam t_dim HEIGHT_RESET = t_dim'(480);
    localparam t_dim DIM_MIN      = t_dim'(3);
    localparam t_dim WIDTH_MAX    = t_dim'(MAX_WIDTH);
    localparam t_dim HEIGHT_MAX   = t_dim'(MAX_HEIGHT);

    localparam t_pix PIX_WHITE  = t_pix'(255);
    localparam t_pix PIX_CLEAR  = t_pix'(0);

    localparam logic [CNT_W-1:0] NBR_MIN = CNT_W'(2);
    localparam logic [CNT_W-1:0] NBR_MAX = CNT_W'(6);

    // window: [row][col], row 0 is the oldest line, col 0 the oldest column
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

    typedef struct packed {
        t_pix upper;
        t_pix middle;
    } t_ls_word;

    typedef struct packed {
        logic interior;
        logic last;
    } t_pos;

    function automatic t_dim clamp_dim(input t_dim v, input t_dim hi);
        t_dim r;
        if (v < DIM_MIN) begin
            r = DIM_MIN;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic thin_delete(input t_win win, input logic phase);
        logic [7:0]       p;
        logic [7:0]       rise;
        logic [CNT_W-1:0] cnt;
        logic             phase_ok;
        // ring P2..P9 in order
        p[0] = (win[0][1] == PIX_WHITE);
        p[1] = (win[0][2] == PIX_WHITE);
        p[2] = (win[1][2] == PIX_WHITE);
        p[3] = (win[2][2] == PIX_WHITE);
        p[4] = (win[2][1] == PIX_WHITE);
        p[5] = (win[2][0] == PIX_WHITE);
        p[6] = (win[1][0] == PIX_WHITE);
        p[7] = (win[0][0] == PIX_WHITE);
        for (int k = 0; k < 8; k++) begin
            rise[k] = !p[k] && p[(k + 1) % 8];
        end
        cnt = CNT_W'($countones(p));
        if (phase == 1'b0) begin
            phase_ok = !(p[0] && p[2] && p[4]) && !(p[2] && p[4] && p[6]);
        end else begin
            phase_ok = !(p[0] && p[2] && p[6]) && !(p[0] && p[4] && p[6]);
        end
        return (win[1][1] == PIX_WHITE) && (cnt >= NBR_MIN) && (cnt <= NBR_MAX)
            && ($countones(rise) == 1) && phase_ok;
    endfunction

endpackage

`default_nettype wire

### sv/zst_line_store.sv
// ----------------------------------------------------------------------------
// zst_line_store
// Two-row line store, one word per column holding the upper and middle
// rows; registered read, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module zst_line_store (
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire zst_pkg::t_col     i_rd_addr,
    output zst_pkg::t_ls_word      o_rd_data,
    input  wire logic              i_wr_en,
    input  wire zst_pkg::t_col     i_wr_addr,
    input  wire zst_pkg::t_ls_word i_wr_data
);

    zst_pkg::t_ls_word r_mem [zst_pkg::MAX_WIDTH];
    zst_pkg::t_ls_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### sv/zst_scan.sv
// ----------------------------------------------------------------------------
// zst_scan
// Raster position counters: column and row of the next pixel, with the
// interior and last-pixel flags for it.
// ----------------------------------------------------------------------------
`default_nettype none

module zst_scan (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_restart,
    input  wire logic           i_step,
    input  wire zst_pkg::t_dim  i_width,
    input  wire zst_pkg::t_dim  i_height,
    output zst_pkg::t_col       o_col,
    output zst_pkg::t_pos       o_pos
);

    zst_pkg::t_col r_col;
    zst_pkg::t_row r_row;
    zst_pkg::t_col n_col;
    zst_pkg::t_row n_row;
    zst_pkg::t_dim w_eff;
    zst_pkg::t_dim h_eff;
    logic          col_last;
    logic          row_last;

    always_comb begin
        w_eff    = zst_pkg::clamp_dim(i_width, zst_pkg::WIDTH_MAX);
        h_eff    = zst_pkg::clamp_dim(i_height, zst_pkg::HEIGHT_MAX);
        col_last = (zst_pkg::DIM_W'(r_col) == w_eff - zst_pkg::DIM_W'(1));
        row_last = (zst_pkg::DIM_W'(r_row) == h_eff - zst_pkg::DIM_W'(1));
        n_col    = r_col;
        n_row    = r_row;
        if (i_step) begin
            if (col_last) begin
                n_col = '0;
                n_row = row_last ? '0 : r_row + zst_pkg::ROW_W'(1);
            end else begin
                n_col = r_col + zst_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col          = r_col;
    assign o_pos.interior = (r_col >= zst_pkg::COL_W'(2)) && (r_row >= zst_pkg::ROW_W'(2));
    assign o_pos.last     = col_last && row_last;

endmodule

`default_nettype wire

### sv/zst_window.sv
// ----------------------------------------------------------------------------
// zst_window
// 3x3 byte window: shift in the upper, middle and current pixel of one
// column per request and carry the position flags alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module zst_window (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire zst_pkg::t_ls_word i_col_data,
    input  wire zst_pkg::t_pix     i_pixel,
    input  wire zst_pkg::t_pos     i_pos,
    output zst_pkg::t_win          o_win,
    output zst_pkg::t_pos          o_pos,
    output logic                   o_valid
);

    zst_pkg::t_win r_win;
    zst_pkg::t_pos r_pos;
    logic          r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= i_col_data.upper;
            r_win[1][2] <= i_col_data.middle;
            r_win[2][2] <= i_pixel;
            r_pos       <= i_pos;
        end
    end

    assign o_win   = r_win;
    assign o_pos   = r_pos;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

### sv/zst_judge.sv
// ----------------------------------------------------------------------------
// zst_judge
// Thinning decision for the window centre and the result register, with
// the per-frame deletion flag.
// ----------------------------------------------------------------------------
`default_nettype none

module zst_judge (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_restart,
    input  wire logic           i_valid,
    input  wire zst_pkg::t_win  i_win,
    input  wire zst_pkg::t_pos  i_pos,
    input  wire logic           i_phase,
    output logic                o_valid,
    output zst_pkg::t_pix       o_pixel,
    output logic                o_deleted,
    output logic                o_last,
    output logic                o_any
);

    logic          r_valid;
    zst_pkg::t_pix r_pixel;
    logic          r_deleted;
    logic          r_last;
    logic          r_any;
    logic          r_changed;
    logic          del;
    logic          emit;

    assign del  = zst_pkg::thin_delete(i_win, i_phase);
    assign emit = i_en && i_valid && i_pos.interior;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_changed <= 1'b0;
        end else begin
            if (i_en) begin
                r_valid <= i_valid && i_pos.interior;
            end
            if (i_restart) begin
                r_changed <= 1'b0;
            end else if (emit) begin
                r_changed <= i_pos.last ? 1'b0 : (r_changed || del);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_pixel   <= del ? zst_pkg::PIX_CLEAR : i_win[1][1];
            r_deleted <= del;
            r_last    <= i_pos.last;
            r_any     <= r_changed || del;
        end
    end

    assign o_valid   = r_valid;
    assign o_pixel   = r_pixel;
    assign o_deleted = r_deleted;
    assign o_last    = r_last;
    assign o_any     = r_any;

endmodule

`default_nettype wire

### sv/zhang_suen_thinning_pass_top.sv
// ----------------------------------------------------------------------------
// zhang_suen_thinning_pass_top
// One Zhang-Suen thinning sub-iteration over a streamed byte raster.
//
//   channel   direction  handshake                  payload
//   input     in         i_valid / o_ready          i_pixel_in
//   result    out        o_valid / i_ready          o_pixel_out, o_deleted,
//                                                   o_last_interior, o_any_deleted
//   config    in         i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// One pixel per cycle sustained while no result waits. Stages: line store
// read, window shift with line store write, decision into the result
// register. The whole pipe holds while a result waits; o_ready is low only
// then. Reset is synchronous and needs no clearing pass; line store words
// read before they were written only reach windows that are not interior.
// ----------------------------------------------------------------------------
`default_nettype none

module zhang_suen_thinning_pass_top (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [zst_pkg::PIX_W-1:0] i_pixel_in,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [zst_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                          o_deleted,
    output logic                          o_last_interior,
    output logic                          o_any_deleted,
    input  wire logic                     i_cfg_we,
    input  wire zst_pkg::t_cfg_idx        i_cfg_idx,
    input  wire logic [zst_pkg::DIM_W-1:0] i_cfg_data
);

    zst_pkg::t_dim     r_width;
    zst_pkg::t_dim     r_height;
    logic              r_phase;
    logic              restart;

    logic              en;
    logic              accept;

    zst_pkg::t_col     scan_col;
    zst_pkg::t_pos     scan_pos;

    logic              r_v1;
    zst_pkg::t_col     r_col1;
    zst_pkg::t_pos     r_pos1;
    zst_pkg::t_pix     r_px1;
    zst_pkg::t_ls_word ls_rd;
    zst_pkg::t_ls_word ls_wr;

    zst_pkg::t_win     win;
    zst_pkg::t_pos     win_pos;
    logic              win_valid;

    assign en      = !o_valid || i_ready;
    assign accept  = i_valid && en;
    assign o_ready = en;

    always_comb begin
        restart = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                zst_pkg::CFG_FRAME_WIDTH:  restart = 1'b1;
                zst_pkg::CFG_FRAME_HEIGHT: restart = 1'b1;
                default:                   restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= zst_pkg::WIDTH_RESET;
            r_height <= zst_pkg::HEIGHT_RESET;
            r_phase  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                zst_pkg::CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                zst_pkg::CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                zst_pkg::CFG_PASS_PHASE:   r_phase  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    zst_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_step    (accept),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_col     (scan_col),
        .o_pos     (scan_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col1 <= scan_col;
            r_pos1 <= scan_pos;
            r_px1  <= i_pixel_in;
        end
    end

    // shift the column down: middle moves to upper, new pixel to middle
    assign ls_wr.upper  = ls_rd.middle;
    assign ls_wr.middle = r_px1;

    zst_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (scan_col),
        .o_rd_data (ls_rd),
        .i_wr_en   (en && r_v1),
        .i_wr_addr (r_col1),
        .i_wr_data (ls_wr)
    );

    zst_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_v1),
        .i_col_data (ls_rd),
        .i_pixel    (r_px1),
        .i_pos      (r_pos1),
        .o_win      (win),
        .o_pos      (win_pos),
        .o_valid    (win_valid)
    );

    zst_judge u_judge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_restart (restart),
        .i_valid   (win_valid),
        .i_win     (win),
        .i_pos     (win_pos),
        .i_phase   (r_phase),
        .o_valid   (o_valid),
        .o_pixel   (o_pixel_out),
        .o_deleted (o_deleted),
        .o_last    (o_last_interior),
        .o_any     (o_any_deleted)
    );

endmodule

`default_nettype wire
